>>> src/bounded_sequence_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded sequence list engine
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SEQUENCE_LIST_ENGINE_MACROS_SVH
`define BOUNDED_SEQUENCE_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define BSLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsle: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define BSLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsle: next-cycle check failed");
`else
`define BSLE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BSLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/bsle_pkg.sv
// ----------------------------------------------------------------------------
// Bounded sequence list engine package
// Request and response types, operation and status codes, cell commands.
// ----------------------------------------------------------------------------
package bsle_pkg;

    localparam int DEF_CAPACITY = 64;

    // Operation codes carried in the request kind field.
    localparam logic [3:0] KIND_PUSH_FRONT = 4'd0;
    localparam logic [3:0] KIND_PUSH_BACK  = 4'd1;
    localparam logic [3:0] KIND_POP_FRONT  = 4'd2;
    localparam logic [3:0] KIND_POP_BACK   = 4'd3;
    localparam logic [3:0] KIND_SEARCH     = 4'd4;
    localparam logic [3:0] KIND_INS_POS    = 4'd5;
    localparam logic [3:0] KIND_INS_ORD    = 4'd6;
    localparam logic [3:0] KIND_DEL_KEY    = 4'd7;
    localparam logic [3:0] KIND_DEL_POS    = 4'd8;
    localparam logic [3:0] KIND_REVERSE    = 4'd9;

    // Response status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BADPOS   = 3'd4;

    typedef struct packed {
        logic [3:0]          kind;
        logic signed [31:0]  value;
        logic [6:0]          position;
    } req_t;

    typedef struct packed {
        logic [2:0]          status;
        logic signed [31:0]  result_value;
        logic [6:0]          found_position;
        logic [6:0]          entry_count;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } cell_op_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t            op;
        logic signed [31:0]  data;
    } cell_cmd_t;

endpackage

>>> src/bsle_cell.sv
// ----------------------------------------------------------------------------
// Bounded sequence list engine cell
// Holds one stored value, compares it with the broadcast key, takes the data
// at the insert slot and a left or right neighbor's value on a row shift.
// ----------------------------------------------------------------------------
module bsle_cell #(
    parameter int IW    = $clog2(bsle_pkg::DEF_CAPACITY),
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  bsle_pkg::cell_cmd_t cmd,
    input  logic [IW-1:0]       idx,
    input  logic signed [31:0]  left_value,
    input  logic signed [31:0]  right_value,
    input  logic signed [31:0]  key,
    output logic signed [31:0]  value,
    output logic                eq,
    output logic                lt
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.op)
            bsle_pkg::CELL_HOLD:
            begin
                value_next = value_reg;
            end
            bsle_pkg::CELL_INS:
            begin
                if (MY_IDX > idx)
                begin
                    value_next = left_value;
                end
                else if (MY_IDX == idx)
                begin
                    value_next = cmd.data;
                end
            end
            bsle_pkg::CELL_DEL:
            begin
                if (MY_IDX >= idx)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign eq    = (value_reg == key);
    assign lt    = (value_reg < key);

endmodule

>>> src/bounded_sequence_list_engine.sv
// ----------------------------------------------------------------------------
// Bounded sequence list engine
// Ordered list of signed 32-bit values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
//  Channel   Signals                         Direction  Moves
//  req       req_valid, req_stall, req_data  in         one operation request
//  rsp       rsp_valid, rsp_stall, rsp_data  out        one response per request
//
// Each request goes through a compare state, in which the cells compare
// against the key in parallel, then an update state, in which the row shifts
// once to open or close a gap. A new request is taken in the update cycle of
// the previous one, but never while the previous one is still in compare.
// The update cycle waits while an earlier response is still held by rsp_stall.
// Reset clears the count, the orientation flag, the controller and rsp_valid;
// cell contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
`include "bounded_sequence_list_engine_macros.svh"

module bounded_sequence_list_engine #(
    parameter int CAPACITY = bsle_pkg::DEF_CAPACITY
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bsle_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bsle_pkg::rsp_t rsp_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = ((CW > 7) ? CW : 7) + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CW-1:0]      count_reg;
    logic               rev_reg;
    bsle_pkg::req_t     req_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] match_next;
    logic signed [31:0] pick_reg;
    logic signed [31:0] pick_next;
    logic [IW-1:0]      tgt_reg;
    logic [IW-1:0]      tgt_next;
    bsle_pkg::rsp_t     rsp_reg;
    bsle_pkg::rsp_t     rsp_next;
    logic               rsp_valid_reg;

    logic               req_accept;
    logic               upd_done;
    logic               finish;

    // Cell row.
    logic signed [31:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_lt;
    bsle_pkg::cell_cmd_t cell_cmd;
    bsle_pkg::cell_op_t  upd_op;
    logic [IW-1:0]       cell_idx;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;

        if (g == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_inner_left
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[g];
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[g+1];
        end

        bsle_cell #(
            .IW    (IW),
            .INDEX (g)
        ) u_cell (
            .clk         (clk),
            .cmd         (cell_cmd),
            .idx         (cell_idx),
            .left_value  (left_value),
            .right_value (right_value),
            .key         (req_reg.value),
            .value       (cell_value[g]),
            .eq          (cell_eq[g]),
            .lt          (cell_lt[g])
        );
    end

    // Handshake and controller.
    assign upd_done   = !rsp_valid_reg || !rsp_stall;
    assign finish     = (state_reg == S_UPD) && upd_done;
    assign req_stall  = !((state_reg == S_IDLE) || finish);
    assign req_accept = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (upd_done)
                begin
                    state_next = req_accept ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Compare cycle: match vector, target cell and picked value.
    logic [WW-1:0] n_w;
    logic [WW-1:0] pos_w;
    logic [WW-1:0] del_j;
    logic [WW-1:0] del_phys;
    logic [WW-1:0] ins_j;
    logic [WW-1:0] ins_phys;
    logic [WW-1:0] tgt_w;
    logic          is_ins;
    logic          key_op;

    assign n_w    = WW'(count_reg);
    assign pos_w  = WW'(req_reg.position);
    assign is_ins = (req_reg.kind == bsle_pkg::KIND_PUSH_FRONT)
                 || (req_reg.kind == bsle_pkg::KIND_PUSH_BACK)
                 || (req_reg.kind == bsle_pkg::KIND_INS_POS)
                 || (req_reg.kind == bsle_pkg::KIND_INS_ORD);
    assign key_op = (req_reg.kind == bsle_pkg::KIND_SEARCH)
                 || (req_reg.kind == bsle_pkg::KIND_DEL_KEY);

    // When the list is reversed, logical slot j lives in cell count-1-j,
    // and a gap before logical slot j opens at cell count-j.
    always_comb
    begin
        if (req_reg.kind == bsle_pkg::KIND_POP_FRONT)
        begin
            del_j = '0;
        end
        else if (req_reg.kind == bsle_pkg::KIND_POP_BACK)
        begin
            del_j = n_w - WW'(1);
        end
        else
        begin
            del_j = pos_w - WW'(1);
        end

        if (req_reg.kind == bsle_pkg::KIND_PUSH_FRONT)
        begin
            ins_j = '0;
        end
        else if (req_reg.kind == bsle_pkg::KIND_PUSH_BACK)
        begin
            ins_j = n_w;
        end
        else
        begin
            ins_j = pos_w - WW'(1);
        end

        del_phys = rev_reg ? (n_w - WW'(1) - del_j) : del_j;
        ins_phys = rev_reg ? (n_w - ins_j) : ins_j;
        tgt_w    = is_ins ? ins_phys : del_phys;
        tgt_next = tgt_w[IW-1:0];

        pick_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_next[i] = (WW'(i) < n_w) && (key_op ? cell_eq[i] : !cell_lt[i]);
            pick_next     = pick_next | (cell_value[i] & {32{tgt_w == WW'(i)}});
        end
    end

    // Update cycle: isolate the first or last hit and decide the shift.
    logic [CAPACITY-1:0] m_rev;
    logic [CAPACITY-1:0] lo_f;
    logic [CAPACITY-1:0] lo_r;
    logic [IW-1:0]       enc_f;
    logic [IW-1:0]       enc_r;
    logic                any_hit;
    logic [WW-1:0]       h_w;
    logic [WW-1:0]       ord_w;
    logic [WW-1:0]       key_fp_w;
    logic [WW-1:0]       fp_w;
    logic [WW-1:0]       n_next_w;
    logic [2:0]          st;
    logic signed [31:0]  rv;
    logic                rev_next;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            m_rev[i] = match_reg[CAPACITY-1-i];
        end
        lo_f    = match_reg & (~match_reg + CAPACITY'(1));
        lo_r    = m_rev & (~m_rev + CAPACITY'(1));
        any_hit = |match_reg;
        enc_f   = '0;
        enc_r   = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (lo_f[i])
            begin
                enc_f = enc_f | IW'(i);
            end
            if (lo_r[i])
            begin
                enc_r = enc_r | IW'(i);
            end
        end

        // Reversed: the first logical hit is the highest cell that hits.
        h_w = rev_reg ? (WW'(CAPACITY - 1) - WW'(enc_r)) : WW'(enc_f);
        if (rev_reg)
        begin
            ord_w    = any_hit ? (h_w + WW'(1)) : '0;
            key_fp_w = n_w - h_w;
        end
        else
        begin
            ord_w    = any_hit ? h_w : n_w;
            key_fp_w = h_w + WW'(1);
        end
    end

    always_comb
    begin
        st       = bsle_pkg::ST_OK;
        rv       = '0;
        fp_w     = '0;
        n_next_w = n_w;
        upd_op   = bsle_pkg::CELL_HOLD;
        cell_idx = tgt_reg;
        rev_next = rev_reg;

        unique case (req_reg.kind)
            bsle_pkg::KIND_PUSH_FRONT, bsle_pkg::KIND_PUSH_BACK,
            bsle_pkg::KIND_INS_POS, bsle_pkg::KIND_INS_ORD:
            begin
                if (n_w >= WW'(CAPACITY))
                begin
                    st = bsle_pkg::ST_FULL;
                end
                else if ((req_reg.kind == bsle_pkg::KIND_INS_POS)
                         && ((pos_w == '0) || (pos_w > n_w + WW'(1))))
                begin
                    st = bsle_pkg::ST_BADPOS;
                end
                else
                begin
                    upd_op   = bsle_pkg::CELL_INS;
                    cell_idx = (req_reg.kind == bsle_pkg::KIND_INS_ORD)
                             ? ord_w[IW-1:0] : tgt_reg;
                    n_next_w = n_w + WW'(1);
                end
            end
            bsle_pkg::KIND_POP_FRONT, bsle_pkg::KIND_POP_BACK,
            bsle_pkg::KIND_SEARCH, bsle_pkg::KIND_DEL_KEY, bsle_pkg::KIND_DEL_POS:
            begin
                if (n_w == '0)
                begin
                    st = bsle_pkg::ST_EMPTY;
                end
                else if (key_op)
                begin
                    if (!any_hit)
                    begin
                        st = bsle_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        rv   = req_reg.value;
                        fp_w = key_fp_w;
                        if (req_reg.kind == bsle_pkg::KIND_DEL_KEY)
                        begin
                            upd_op   = bsle_pkg::CELL_DEL;
                            cell_idx = h_w[IW-1:0];
                            n_next_w = n_w - WW'(1);
                        end
                    end
                end
                else if ((req_reg.kind == bsle_pkg::KIND_DEL_POS)
                         && ((pos_w == '0) || (pos_w > n_w)))
                begin
                    st = bsle_pkg::ST_BADPOS;
                end
                else
                begin
                    rv       = pick_reg;
                    upd_op   = bsle_pkg::CELL_DEL;
                    n_next_w = n_w - WW'(1);
                    if (req_reg.kind == bsle_pkg::KIND_POP_FRONT)
                    begin
                        fp_w = WW'(1);
                    end
                    else if (req_reg.kind == bsle_pkg::KIND_POP_BACK)
                    begin
                        fp_w = n_w;
                    end
                    else
                    begin
                        fp_w = pos_w;
                    end
                end
            end
            bsle_pkg::KIND_REVERSE:
            begin
                // Reversal only flips how cells map to list order.
                rev_next = !rev_reg;
            end
            default:
            begin
                st = bsle_pkg::ST_OK;
            end
        endcase

        rsp_next.status         = st;
        rsp_next.result_value   = rv;
        rsp_next.found_position = fp_w[6:0];
        rsp_next.entry_count    = n_next_w[6:0];
    end

    assign cell_cmd.op   = finish ? upd_op : bsle_pkg::CELL_HOLD;
    assign cell_cmd.data = req_reg.value;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                count_reg     <= n_next_w[CW-1:0];
                rev_reg       <= rev_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_reg <= req_data;
        end
        if (state_reg == S_CMP)
        begin
            match_reg <= match_next;
            pick_reg  <= pick_next;
            tgt_reg   <= tgt_next;
        end
        if (finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `BSLE_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `BSLE_ASSERT_NEXT(a_accept_to_cmp, clk, rst_n, req_accept, state_reg == S_CMP)
    `BSLE_ASSERT_NEXT(a_count_only_on_finish, clk, rst_n, !finish, count_reg == $past(count_reg))
    `BSLE_ASSERT_SAME(a_rsp_from_update, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg == S_UPD))

endmodule

>>> verif/bounded_sequence_list_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded sequence list engine checker
// Watches the request and response channels, keeps a shadow copy of the
// list, predicts one response per accepted request and compares each
// accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_sequence_list_engine_checker #(
    parameter int CAPACITY = bsle_pkg::DEF_CAPACITY
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  bsle_pkg::req_t req_data,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  bsle_pkg::rsp_t rsp_data,
    output int             mismatches,
    output int             outstanding
);

    import bsle_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic signed [31:0] shadow_list[$];
    rsp_t               predicted_rsp[$];

    // Applies one request to the shadow list and returns the response it causes.
    function automatic rsp_t apply_operation(req_t r);
        rsp_t               a;
        int                 idx;
        int                 pos;
        int                 n;
        logic signed [31:0] swap;
        a   = '0;
        pos = int'(r.position);
        n   = shadow_list.size();
        case (r.kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INS_POS, KIND_INS_ORD:
            begin
                // A full list rejects every insert before the position is looked at.
                if (n >= CAPACITY)
                begin
                    a.status = ST_FULL;
                end
                else if (r.kind == KIND_PUSH_FRONT)
                begin
                    shadow_list.push_front(r.value);
                end
                else if (r.kind == KIND_PUSH_BACK)
                begin
                    shadow_list.push_back(r.value);
                end
                else
                begin
                    if (r.kind == KIND_INS_POS)
                    begin
                        idx = pos - 1;
                    end
                    else
                    begin
                        idx = 0;
                        while (idx < n && shadow_list[idx] < r.value)
                            idx++;
                    end
                    if (r.kind == KIND_INS_POS && (pos < 1 || pos > n + 1))
                        a.status = ST_BADPOS;
                    else if (idx == n)
                        shadow_list.push_back(r.value);
                    else
                        shadow_list.insert(idx, r.value);
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK, KIND_SEARCH, KIND_DEL_KEY, KIND_DEL_POS:
            begin
                if (n == 0)
                begin
                    a.status = ST_EMPTY;
                end
                else if (r.kind == KIND_POP_FRONT)
                begin
                    a.result_value   = shadow_list.pop_front();
                    a.found_position = 7'd1;
                end
                else if (r.kind == KIND_POP_BACK)
                begin
                    a.found_position = 7'(n);
                    a.result_value   = shadow_list.pop_back();
                end
                else if (r.kind == KIND_DEL_POS)
                begin
                    if (pos < 1 || pos > n)
                    begin
                        a.status = ST_BADPOS;
                    end
                    else
                    begin
                        a.result_value   = shadow_list[pos - 1];
                        a.found_position = 7'(pos);
                        shadow_list.delete(pos - 1);
                    end
                end
                else
                begin
                    // Search and delete by key act on the first match from the front.
                    idx = 0;
                    while (idx < n && shadow_list[idx] != r.value)
                        idx++;
                    if (idx == n)
                    begin
                        a.status = ST_NOTFOUND;
                    end
                    else
                    begin
                        a.result_value   = shadow_list[idx];
                        a.found_position = 7'(idx + 1);
                        if (r.kind == KIND_DEL_KEY)
                            shadow_list.delete(idx);
                    end
                end
            end
            KIND_REVERSE:
            begin
                for (idx = 0; idx < n / 2; idx++)
                begin
                    swap                     = shadow_list[idx];
                    shadow_list[idx]         = shadow_list[n - 1 - idx];
                    shadow_list[n - 1 - idx] = swap;
                end
            end
            default:
            begin
            end
        endcase
        a.entry_count = 7'(shadow_list.size());
        return a;
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            // A response can never belong to the request accepted at the same edge.
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_rsp.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected response: status %0d value %0d pos %0d count %0d",
                                 rsp_data.status, rsp_data.result_value,
                                 rsp_data.found_position, rsp_data.entry_count);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = predicted_rsp.pop_front();
                    if (rsp_data.status !== want.status
                        || rsp_data.result_value !== want.result_value
                        || rsp_data.found_position !== want.found_position
                        || rsp_data.entry_count !== want.entry_count)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $write("response mismatch: expected status %0d value %0d ",
                                   want.status, want.result_value);
                            $write("pos %0d count %0d, ",
                                   want.found_position, want.entry_count);
                            $display("got status %0d value %0d pos %0d count %0d",
                                     rsp_data.status, rsp_data.result_value,
                                     rsp_data.found_position, rsp_data.entry_count);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (req_valid && !req_stall)
                predicted_rsp.push_back(apply_operation(req_data));
        end
        outstanding <= predicted_rsp.size();
    end

endmodule

>>> verif/bounded_sequence_list_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded sequence list engine testbench
// Drives a directed run over the empty and bad position cases, then
// random segments that fill, mix and drain the list under changing idle
// patterns on both channels. A checker beside the block does the compare.
// ----------------------------------------------------------------------------
module bounded_sequence_list_engine_test;

    import bsle_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int SEGMENTS       = 15;
    localparam int SEGMENT_ITEMS  = 100;

    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    localparam int MIX_FILL     = 0;
    localparam int MIX_BALANCED = 1;
    localparam int MIX_DRAIN    = 2;

    localparam logic [3:0] KIND_UNUSED = 4'd15;

    localparam logic signed [31:0] VALUE_MIN = 32'sh80000000;
    localparam logic signed [31:0] VALUE_MAX = 32'sh7fffffff;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;
    int   idle_mode = IDLE_NONE;
    int   mismatches;
    int   outstanding;
    int   quiet_cycles;

    bounded_sequence_list_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    bounded_sequence_list_engine_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        case (idle_mode)
            IDLE_RECEIVER: rsp_stall <= ($urandom_range(0, 99) < 46);
            IDLE_BOTH:     rsp_stall <= ($urandom_range(0, 99) < 15);
            default:       rsp_stall <= 1'b0;
        endcase
    end

    // Ends the run when no request or response moves for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("bounded_sequence_list_engine_test failed");
        $finish;
    end

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $signed(32'($urandom_range(0, 15))) - 32'sd8;
        else if (sel < 8)
            return $signed(32'($urandom));
        else if (sel == 8)
            return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
        else
            return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
    endfunction

    function automatic logic [6:0] pick_position();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 7'($urandom_range(1, 20));
        else if (sel < 9)
            return 7'($urandom_range(0, 66));
        else
            return 7'($urandom_range(0, 127));
    endfunction

    function automatic req_t make_random_request(int mix);
        req_t r;
        int   roll;
        int   insert_pct;
        insert_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_BALANCED) ? 45 : 10;
        r.value    = pick_value();
        r.position = pick_position();
        roll       = $urandom_range(0, 99);
        if (roll < 3)
        begin
            r.kind = 4'($urandom_range(10, 15));
        end
        else if (roll < 6)
        begin
            r.kind = KIND_REVERSE;
        end
        else if ($urandom_range(0, 99) < insert_pct)
        begin
            case ($urandom_range(0, 3))
                0:       r.kind = KIND_PUSH_FRONT;
                1:       r.kind = KIND_PUSH_BACK;
                2:       r.kind = KIND_INS_POS;
                default: r.kind = KIND_INS_ORD;
            endcase
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:       r.kind = KIND_POP_FRONT;
                1:       r.kind = KIND_POP_BACK;
                2:       r.kind = KIND_SEARCH;
                3:       r.kind = KIND_DEL_KEY;
                default: r.kind = KIND_DEL_POS;
            endcase
        end
        return r;
    endfunction

    // Holds the request until it is accepted; returns in the step of acceptance.
    task automatic send_request(req_t r);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 46 : (idle_mode == IDLE_BOTH) ? 15 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
    endtask

    task automatic send_op(logic [3:0] kind, logic signed [31:0] value, logic [6:0] position);
        req_t r;
        r.kind     = kind;
        r.value    = value;
        r.position = position;
        send_request(r);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reverse, pops, search and deletes on an empty list, and inserts at bad positions.
        send_op(KIND_REVERSE,   32'sd0, 7'd0);
        send_op(KIND_POP_FRONT, 32'sd0, 7'd1);
        send_op(KIND_POP_BACK,  32'sd0, 7'd1);
        send_op(KIND_SEARCH,    32'sd0, 7'd1);
        send_op(KIND_DEL_KEY,   32'sd0, 7'd1);
        send_op(KIND_DEL_POS,   32'sd0, 7'd1);
        send_op(KIND_INS_POS,   32'sd3, 7'd0);
        send_op(KIND_INS_POS,   32'sd3, 7'd2);
        // Build MIN, 5, -1, 0, MAX, 5 to exercise signed order and duplicates.
        send_op(KIND_PUSH_FRONT, VALUE_MIN, 7'd0);
        send_op(KIND_PUSH_BACK,  VALUE_MAX, 7'd0);
        send_op(KIND_INS_ORD,    32'sd0,    7'd0);
        send_op(KIND_INS_ORD,    -32'sd1,   7'd0);
        send_op(KIND_INS_POS,    32'sd5,    7'd2);
        send_op(KIND_INS_POS,    32'sd5,    7'd6);
        send_op(KIND_SEARCH,     32'sd5,    7'd0);
        send_op(KIND_SEARCH,     32'sd1234, 7'd0);
        send_op(KIND_DEL_POS,    32'sd0,    7'd0);
        send_op(KIND_DEL_POS,    32'sd0,    7'd7);
        send_op(KIND_DEL_POS,    32'sd0,    7'd127);
        send_op(KIND_DEL_KEY,    32'sd5,    7'd0);
        send_op(KIND_REVERSE,    32'sd0,    7'd0);
        send_op(KIND_POP_FRONT,  32'sd0,    7'd0);
        send_op(KIND_POP_BACK,   32'sd0,    7'd0);
        send_op(KIND_DEL_POS,    32'sd0,    7'd2);
        send_op(KIND_UNUSED,     -32'sd1,   7'd127);

        // Segments rotate through fill, mixed and drain traffic so that the
        // list repeatedly reaches both full and empty under each idle pattern.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_mode = seg % 4;
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                send_request(make_random_request(seg % 3));
        end

        req_valid <= 1'b0;
        idle_mode = IDLE_NONE;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("bounded_sequence_list_engine_test passed");
        else
            $display("bounded_sequence_list_engine_test failed");
        $finish;
    end

endmodule
